### rtl/ndacc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ndacc_pkg
// Types and constants shared by the Nei distance accumulator modules.
// ----------------------------------------------------------------------------
package ndacc_pkg;

    localparam int POOLS      = 4;
    localparam int PAIRS      = (POOLS * (POOLS - 1)) / 2;
    localparam int POOL_W     = $clog2(POOLS);
    localparam int PAIR_W     = $clog2(PAIRS);
    localparam int FREQ_W     = 16;
    localparam int NEFF_W     = 24;
    localparam int SUM_W      = 34;
    localparam int PROD_W     = 2 * FREQ_W;
    localparam int CNT_W      = 24;
    localparam int OUT_ACC_W  = 48;
    localparam int NUM_W      = 43;   // signed (1 - W) << 8
    localparam int MAG_W      = NUM_W - 1;
    localparam int UNB_W      = 45;   // signed unbiased square sum, Q.32
    localparam int TERM_W     = 38;   // signed term, Q.24

    localparam logic [NEFF_W-1:0] NEFF_ONE  = NEFF_W'(256);
    localparam logic [SUM_W:0]    ONE_Q32   = (SUM_W + 1)'(1) << 32;
    localparam logic [SUM_W-1:0]  SUM_MAX   = '1;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_pool0;
        logic [FREQ_W-1:0] freq_pool1;
        logic [FREQ_W-1:0] freq_pool2;
        logic [FREQ_W-1:0] freq_pool3;
        logic [NEFF_W-1:0] neff_pool0;
        logic [NEFF_W-1:0] neff_pool1;
        logic [NEFF_W-1:0] neff_pool2;
        logic [NEFF_W-1:0] neff_pool3;
        logic              site_last;
        logic              data_last;
    } in_data_t;

    typedef struct packed {
        logic [POOL_W-1:0]           pool_a;
        logic [POOL_W-1:0]           pool_b;
        logic signed [OUT_ACC_W-1:0] raw_total;
        logic signed [OUT_ACC_W-1:0] corrected_total;
        logic [CNT_W-1:0]            site_total;
        logic                        last_pair;
    } out_data_t;

    typedef struct packed {
        logic mul_en;
        logic sum_en;
        logic site_clr;
    } pool_ctrl_t;

    typedef struct packed {
        logic mul_en;
        logic sum_en;
        logic site_clr;
        logic term_en;
        logic tot_en;
        logic tot_clr;
    } pair_ctrl_t;

    function automatic int pair_index(input int a, input int b);
        return (a * (2 * POOLS - a - 1)) / 2 + (b - a - 1);
    endfunction

endpackage
`default_nettype wire

### rtl/ndacc_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ndacc_stream_if
// Valid/ready channel carrying one item of payload type T.
// ----------------------------------------------------------------------------
interface ndacc_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/ndacc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ndacc_div
// Serial restoring divider, one quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module ndacc_div
    import ndacc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [NUM_W-1:0] num,
    input  wire logic [NEFF_W-1:0]       den,
    output logic                         done,
    output logic signed [NUM_W-1:0]      quo
);

    localparam int CW = $clog2(MAG_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              neg_reg, neg_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic [NEFF_W-1:0] rem_reg, rem_next;
    logic [NEFF_W-1:0] den_reg, den_next;
    logic [NEFF_W:0]   trial;
    logic [NUM_W-1:0]  abs_num;

    always_comb
    begin
        abs_num   = num[NUM_W-1] ? (-num) : num;
        trial     = {rem_reg, mag_reg[MAG_W-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = num[NUM_W-1];
            mag_next  = abs_num[MAG_W-1:0];
            rem_next  = '0;
            den_next  = den;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = NEFF_W'(trial - {1'b0, den_reg});
                mag_next = {mag_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[NEFF_W-1:0];
                mag_next = {mag_reg[MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(MAG_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});

endmodule
`default_nettype wire

### rtl/ndacc_pool_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ndacc_pool_lane
// One pool: squared frequency sum over a site and its unbiased form.
// ----------------------------------------------------------------------------
module ndacc_pool_lane
    import ndacc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire pool_ctrl_t              ctrl,
    input  wire logic [FREQ_W-1:0]       freq,
    input  wire logic                    unb_load,
    input  wire logic signed [NUM_W-1:0] quo,
    output logic [SUM_W-1:0]             w,
    output logic signed [UNB_W-1:0]      unb
);

    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic signed [UNB_W-1:0] unb_reg, unb_next;
    logic [SUM_W:0]          add;

    always_comb
    begin
        prod_next = ctrl.mul_en ? freq * freq : prod_reg;
        add       = {1'b0, sum_reg} + (SUM_W + 1)'(prod_reg);
        sum_next  = sum_reg;
        if (ctrl.site_clr)
            sum_next = '0;
        else if (ctrl.sum_en)
            sum_next = add[SUM_W] ? SUM_MAX : add[SUM_W-1:0];
        unb_next = unb_reg;
        if (unb_load)
            unb_next = $signed(UNB_W'(sum_reg)) - UNB_W'(quo);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else
            sum_reg <= sum_next;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        unb_reg  <= unb_next;
    end

    assign w   = sum_reg;
    assign unb = unb_reg;

endmodule
`default_nettype wire

### rtl/ndacc_pair_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ndacc_pair_lane
// One pool pair: cross product sum, Nei terms and saturating totals.
// ----------------------------------------------------------------------------
module ndacc_pair_lane
    import ndacc_pkg::*;
#(
    parameter int ACC_WIDTH = 48
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire pair_ctrl_t              ctrl,
    input  wire logic [FREQ_W-1:0]       freq_a,
    input  wire logic [FREQ_W-1:0]       freq_b,
    input  wire logic [SUM_W-1:0]        w_a,
    input  wire logic [SUM_W-1:0]        w_b,
    input  wire logic signed [UNB_W-1:0] unb_a,
    input  wire logic signed [UNB_W-1:0] unb_b,
    input  wire logic                    pair_ok,
    output logic signed [ACC_WIDTH-1:0]  raw_tot,
    output logic signed [ACC_WIDTH-1:0]  corr_tot,
    output logic [CNT_W-1:0]             cnt
);

    localparam int SW = (ACC_WIDTH > TERM_W ? ACC_WIDTH : TERM_W) + 1;
    localparam logic signed [SW-1:0] AMAX = (SW'(1) <<< (ACC_WIDTH - 1)) - SW'(1);
    localparam logic signed [SW-1:0] AMIN = -AMAX - SW'(1);

    logic [PROD_W-1:0]           prod_reg, prod_next;
    logic [SUM_W-1:0]            cross_reg, cross_next;
    logic signed [TERM_W-1:0]    raw_term_reg, raw_term_next;
    logic signed [TERM_W-1:0]    corr_term_reg, corr_term_next;
    logic                        ok_reg, ok_next;
    logic signed [ACC_WIDTH-1:0] raw_reg, raw_next;
    logic signed [ACC_WIDTH-1:0] corr_reg, corr_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [SUM_W:0]              add;
    logic signed [UNB_W+1:0]     raw_q33, corr_q33;
    logic signed [UNB_W+1:0]     raw_q24, corr_q24;
    logic signed [SW-1:0]        raw_sum, corr_sum;

    function automatic logic signed [ACC_WIDTH-1:0] clamp(input logic signed [SW-1:0] v);
        if (v > AMAX)
            return AMAX[ACC_WIDTH-1:0];
        else if (v < AMIN)
            return AMIN[ACC_WIDTH-1:0];
        return v[ACC_WIDTH-1:0];
    endfunction

    always_comb
    begin
        prod_next  = ctrl.mul_en ? freq_a * freq_b : prod_reg;
        add        = {1'b0, cross_reg} + (SUM_W + 1)'(prod_reg);
        cross_next = cross_reg;
        if (ctrl.site_clr)
            cross_next = '0;
        else if (ctrl.sum_en)
            cross_next = add[SUM_W] ? SUM_MAX : add[SUM_W-1:0];

        // Q.33 terms, then floor to Q.24
        raw_q33  = $signed((UNB_W + 2)'(w_a)) + $signed((UNB_W + 2)'(w_b))
                 - $signed((UNB_W + 2)'({cross_reg, 1'b0}));
        corr_q33 = (UNB_W + 2)'(unb_a) + (UNB_W + 2)'(unb_b)
                 - $signed((UNB_W + 2)'({cross_reg, 1'b0}));
        raw_q24  = raw_q33 >>> 9;
        corr_q24 = corr_q33 >>> 9;
        raw_term_next  = ctrl.term_en ? raw_q24[TERM_W-1:0] : raw_term_reg;
        corr_term_next = ctrl.term_en ? corr_q24[TERM_W-1:0] : corr_term_reg;
        ok_next        = ctrl.term_en ? pair_ok : ok_reg;

        raw_sum  = SW'(raw_reg) + SW'(raw_term_reg);
        corr_sum = SW'(corr_reg) + SW'(corr_term_reg);
        raw_next  = raw_reg;
        corr_next = corr_reg;
        cnt_next  = cnt_reg;
        if (ctrl.tot_clr)
        begin
            raw_next  = '0;
            corr_next = '0;
            cnt_next  = '0;
        end
        else if (ctrl.tot_en && ok_reg)
        begin
            raw_next  = clamp(raw_sum);
            corr_next = clamp(corr_sum);
            if (cnt_reg != '1)
                cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cross_reg <= '0;
            raw_reg   <= '0;
            corr_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            cross_reg <= cross_next;
            raw_reg   <= raw_next;
            corr_reg  <= corr_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        raw_term_reg  <= raw_term_next;
        corr_term_reg <= corr_term_next;
        ok_reg        <= ok_next;
    end

    assign raw_tot  = raw_reg;
    assign corr_tot = corr_reg;
    assign cnt      = cnt_reg;

endmodule
`default_nettype wire

### rtl/nei_distance_accumulator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nei_distance_accumulator_unit
// Sample-size-corrected Nei distance totals for every pool pair.
// ----------------------------------------------------------------------------
// One item is taken at a time. A row that does not close a site is accepted,
// multiplied in every lane and accumulated. A row that closes a site adds
// the site-end pass: for each pool with a usable sample size the shared
// serial divider runs, then the pair terms are formed and added. A final
// row then streams the six pair results through an output register, one a
// cycle while the sink takes them; the last result may still wait in that
// register while the next row is taken.
// ----------------------------------------------------------------------------
module nei_distance_accumulator_unit
    import ndacc_pkg::*;
#(
    parameter int ACC_WIDTH = 48
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    ndacc_stream_if.sink   in_item,
    ndacc_stream_if.source out_item
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_SUM  = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_TERM = 7'b0010000,
        S_ACC  = 7'b0100000,
        S_EMIT = 7'b1000000
    } state_t;

    localparam int XW = ACC_WIDTH > OUT_ACC_W ? ACC_WIDTH : OUT_ACC_W;

    state_t            state_reg, state_next;
    in_data_t          row_reg, row_next;
    logic [POOL_W-1:0] pool_idx_reg, pool_idx_next;
    logic              div_run_reg, div_run_next;
    logic [PAIR_W-1:0] emit_k_reg, emit_k_next;
    logic [POOL_W-1:0] emit_a_reg, emit_a_next;
    logic [POOL_W-1:0] emit_b_reg, emit_b_next;
    out_data_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic [FREQ_W-1:0]           freq [POOLS];
    logic [NEFF_W-1:0]           neff [POOLS];
    logic                        ok [POOLS];
    logic [SUM_W-1:0]            w_arr [POOLS];
    logic signed [UNB_W-1:0]     unb_arr [POOLS];
    logic signed [ACC_WIDTH-1:0] raw_arr [PAIRS];
    logic signed [ACC_WIDTH-1:0] corr_arr [PAIRS];
    logic [CNT_W-1:0]            cnt_arr [PAIRS];

    pool_ctrl_t              pool_ctrl;
    pair_ctrl_t              pair_ctrl;
    logic                    accept, slot_free, closing;
    logic                    div_start, div_done;
    logic signed [NUM_W-1:0] div_num, div_quo;
    logic [NEFF_W-1:0]       div_den;
    logic signed [SUM_W:0]   one_minus_w;
    logic signed [XW-1:0]    raw_ext, corr_ext;

    assign freq[0] = row_reg.freq_pool0;
    assign freq[1] = row_reg.freq_pool1;
    assign freq[2] = row_reg.freq_pool2;
    assign freq[3] = row_reg.freq_pool3;
    assign neff[0] = row_reg.neff_pool0;
    assign neff[1] = row_reg.neff_pool1;
    assign neff[2] = row_reg.neff_pool2;
    assign neff[3] = row_reg.neff_pool3;

    assign accept    = in_item.valid && in_item.ready;
    assign slot_free = !out_valid_reg || out_item.ready;
    assign closing   = row_reg.site_last || row_reg.data_last;

    assign pool_ctrl.mul_en   = (state_reg == S_MUL);
    assign pool_ctrl.sum_en   = (state_reg == S_SUM);
    assign pool_ctrl.site_clr = (state_reg == S_ACC);
    assign pair_ctrl.mul_en   = (state_reg == S_MUL);
    assign pair_ctrl.sum_en   = (state_reg == S_SUM);
    assign pair_ctrl.site_clr = (state_reg == S_ACC);
    assign pair_ctrl.term_en  = (state_reg == S_TERM);
    assign pair_ctrl.tot_en   = (state_reg == S_ACC);
    assign pair_ctrl.tot_clr  = (state_reg == S_EMIT) && slot_free
                              && (emit_k_reg == PAIR_W'(PAIRS - 1));

    genvar gp, ga, gb;
    generate
        for (gp = 0; gp < POOLS; gp++)
        begin : g_pool
            assign ok[gp] = neff[gp] > NEFF_ONE;
            ndacc_pool_lane u_lane (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (pool_ctrl),
                .freq     (freq[gp]),
                .unb_load (div_done && div_run_reg && (state_reg == S_DIV)
                           && (pool_idx_reg == POOL_W'(gp))),
                .quo      (div_quo),
                .w        (w_arr[gp]),
                .unb      (unb_arr[gp])
            );
        end
        for (ga = 0; ga < POOLS; ga++)
        begin : g_a
            for (gb = ga + 1; gb < POOLS; gb++)
            begin : g_b
                localparam int K = pair_index(ga, gb);
                ndacc_pair_lane #(.ACC_WIDTH(ACC_WIDTH)) u_lane (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctrl     (pair_ctrl),
                    .freq_a   (freq[ga]),
                    .freq_b   (freq[gb]),
                    .w_a      (w_arr[ga]),
                    .w_b      (w_arr[gb]),
                    .unb_a    (unb_arr[ga]),
                    .unb_b    (unb_arr[gb]),
                    .pair_ok  (ok[ga] && ok[gb]),
                    .raw_tot  (raw_arr[K]),
                    .corr_tot (corr_arr[K]),
                    .cnt      (cnt_arr[K])
                );
            end
        end
    endgenerate

    // Shared divider: (1 - W) << 8 over (neff - 1), one pool at a time
    assign one_minus_w = $signed(ONE_Q32) - $signed({1'b0, w_arr[pool_idx_reg]});
    assign div_num     = {one_minus_w[SUM_W:0], 8'b0};
    assign div_den     = neff[pool_idx_reg] - NEFF_ONE;
    assign div_start   = (state_reg == S_DIV) && !div_run_reg && ok[pool_idx_reg];

    ndacc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign raw_ext  = XW'(raw_arr[emit_k_reg]);
    assign corr_ext = XW'(corr_arr[emit_k_reg]);

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        pool_idx_next  = pool_idx_reg;
        div_run_next   = div_run_reg;
        emit_k_next    = emit_k_reg;
        emit_a_next    = emit_a_reg;
        emit_b_next    = emit_b_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_item.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    row_next   = in_item.data;
                    state_next = S_MUL;
                end
            end
            S_MUL:
                state_next = S_SUM;
            S_SUM:
            begin
                pool_idx_next = '0;
                div_run_next  = 1'b0;
                state_next    = closing ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                if (div_start)
                    div_run_next = 1'b1;
                else if (!div_run_reg || div_done)
                begin
                    // pool finished or skipped: advance
                    div_run_next = 1'b0;
                    if (pool_idx_reg == POOL_W'(POOLS - 1))
                        state_next = S_TERM;
                    else
                        pool_idx_next = pool_idx_reg + POOL_W'(1);
                end
            end
            S_TERM:
                state_next = S_ACC;
            S_ACC:
            begin
                emit_k_next = '0;
                emit_a_next = '0;
                emit_b_next = POOL_W'(1);
                state_next  = row_reg.data_last ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_next.pool_a          = emit_a_reg;
                    out_next.pool_b          = emit_b_reg;
                    out_next.raw_total       = raw_ext[OUT_ACC_W-1:0];
                    out_next.corrected_total = corr_ext[OUT_ACC_W-1:0];
                    out_next.site_total      = cnt_arr[emit_k_reg];
                    out_next.last_pair       = (emit_k_reg == PAIR_W'(PAIRS - 1));
                    out_valid_next           = 1'b1;
                    emit_k_next              = emit_k_reg + PAIR_W'(1);
                    if (emit_b_reg == POOL_W'(POOLS - 1))
                    begin
                        emit_a_next = emit_a_reg + POOL_W'(1);
                        emit_b_next = emit_a_reg + POOL_W'(2);
                    end
                    else
                        emit_b_next = emit_b_reg + POOL_W'(1);
                    if (emit_k_reg == PAIR_W'(PAIRS - 1))
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pool_idx_reg  <= '0;
            div_run_reg   <= 1'b0;
            emit_k_reg    <= '0;
            emit_a_reg    <= '0;
            emit_b_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pool_idx_reg  <= pool_idx_next;
            div_run_reg   <= div_run_next;
            emit_k_reg    <= emit_k_next;
            emit_a_reg    <= emit_a_next;
            emit_b_reg    <= emit_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        out_reg <= out_next;
    end

    assign in_item.ready  = (state_reg == S_IDLE);
    assign out_item.valid = out_valid_reg;
    assign out_item.data  = out_reg;

    // One row is worked on at a time
    a_one_row: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_item.ready)
        else $error("item taken while a row is still in progress");

    // The divider is only started during the site-end pass on a usable pool
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (state_reg == S_DIV) && (neff[pool_idx_reg] > NEFF_ONE))
        else $error("divider started outside the site-end pass");

    // The closing result of a run belongs to the highest pair
    a_last_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (out_item.valid && out_item.data.last_pair) |->
        (out_item.data.pool_a == POOL_W'(POOLS - 2))
        && (out_item.data.pool_b == POOL_W'(POOLS - 1)))
        else $error("last pair flag on the wrong pair");

endmodule
`default_nettype wire
